FILE: hdl/flhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flhs_pkg;

	localparam int FALL_N = 11;
	localparam int RISE_N = 9;

	localparam logic [15:0] FALL_LIMIT [FALL_N] = '{
		16'h3700, 16'h374a, 16'h3800, 16'h3900, 16'h3a4a, 16'h3ad3,
		16'h3b3c, 16'h3b94, 16'h3be3, 16'h3c29, 16'hffff
	};
	localparam logic [3:0] FALL_LEVEL [FALL_N] = '{
		4'd11, 4'd6, 4'd7, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
	};
	localparam logic [15:0] RISE_LIMIT [RISE_N] = '{
		16'h0000, 16'h3900, 16'h3a4a, 16'h3ad3, 16'h3b3c,
		16'h3b94, 16'h3be3, 16'h3c29, 16'hffff
	};
	localparam logic [3:0] RISE_LEVEL [RISE_N] = '{
		4'd11, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
	};

	localparam logic [3:0] FALL_RESET = 4'd1;
	localparam logic [2:0] RISE_RESET = 3'd1;

	typedef struct packed {
		logic [3:0] fall_band;
		logic [2:0] rise_band;
	} bands_t;

	typedef struct packed {
		logic       chosen;
		logic [3:0] setting;
		logic [6:0] ctrl_byte;
		logic       by_rise;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/fan_level_hysteresis_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Fan level selector with two-band hysteresis.
//
// Input channel: in_valid / in_stall carry one item per poll: temp_reading
// (8.8 fixed point, unsigned) and reading_valid. An item with reading_valid
// low is accepted and dropped without touching the band state.
// Output channel: out_valid / out_stall carry fan_level, fan_control_byte
// and chosen_by_rise, only for items that select a new setting.
//
// Timing: an accepted item is registered at the accepting edge, the band
// compare runs combinationally on it, and its result lands in the output
// register at an edge when the output is free. Throughput: one item per
// cycle through the single compare stage, unless a chosen result is stalled.
//
// Reset (arst_n low) clears both registers' valid flags and sets the
// falling and rising bands to 1.
// When the receiver stalls with a result waiting, the staged item holds only
// if it would produce a result too; items that produce nothing still drain.
module fan_level_hysteresis_selector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] temp_reading,
	input  wire logic        reading_valid,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       fan_level,
	output logic [6:0]       fan_control_byte,
	output logic             chosen_by_rise
);

	// input stage
	logic             valid_s1;
	logic [15:0]      temp_s1;
	logic             rd_ok_s1;

	// band state
	flhs_pkg::bands_t bands_q;
	flhs_pkg::bands_t next_bands;
	flhs_pkg::result_t result;

	logic out_free;
	logic advance;

	flhs_band_eval u_eval (
		.temp_reading  (temp_s1),
		.reading_valid (rd_ok_s1),
		.cur_bands     (bands_q),
		.next_bands    (next_bands),
		.result        (result)
	);

	assign out_free = !out_valid || !out_stall;
	// staged item leaves unless it needs the output slot and that is busy
	assign advance  = valid_s1 && (!result.chosen || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			temp_s1  <= temp_reading;
			rd_ok_s1 <= reading_valid;
		end
	end

	// both bands are stored on every valid read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q.fall_band <= flhs_pkg::FALL_RESET;
			bands_q.rise_band <= flhs_pkg::RISE_RESET;
		end else if (advance && rd_ok_s1) begin
			bands_q <= next_bands;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && result.chosen;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && result.chosen) begin
			fan_level        <= result.setting;
			fan_control_byte <= result.ctrl_byte;
			chosen_by_rise   <= result.by_rise;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/flhs_band_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Band lookup and hysteresis decision for one reading.
module flhs_band_eval (
	input  wire logic [15:0]     temp_reading,
	input  wire logic            reading_valid,
	input  wire flhs_pkg::bands_t cur_bands,
	output flhs_pkg::bands_t     next_bands,
	output flhs_pkg::result_t    result
);

	logic [15:0] rise_temp;
	logic [3:0]  fi;
	logic [2:0]  ri;
	logic        fall_hit;
	logic        rise_hit;
	logic [3:0]  level;

	// both tables ascend, so the scan index is a count of passed limits
	always_comb begin
		rise_temp = {temp_reading[15:1], 1'b0};
		fi = '0;
		for (int i = 0; i < flhs_pkg::FALL_N - 1; i++) begin
			if (temp_reading > flhs_pkg::FALL_LIMIT[i]) begin
				fi = fi + 4'd1;
			end
		end
		ri = '0;
		for (int j = 1; j < flhs_pkg::RISE_N - 1; j++) begin
			if (rise_temp >= flhs_pkg::RISE_LIMIT[j]) begin
				ri = ri + 3'd1;
			end
		end
	end

	always_comb begin
		fall_hit = fi < cur_bands.fall_band;
		rise_hit = cur_bands.rise_band < ri;
		// rise overrides fall
		level = rise_hit ? flhs_pkg::RISE_LEVEL[{1'b0, ri}] : flhs_pkg::FALL_LEVEL[fi];

		next_bands.fall_band = fi;
		next_bands.rise_band = ri;

		result.chosen    = reading_valid & (fall_hit | rise_hit);
		result.setting   = level;
		result.ctrl_byte = {level, 3'b111};
		result.by_rise   = rise_hit;
	end

endmodule

`default_nettype wire

FILE: verif/tb_fan_level_hysteresis_selector.sv
`timescale 1ns / 1ps

// Testbench for the fan level selector.
// The sender changes the inputs on the falling edge. Monitors sample both
// handshakes on the rising edge and feed the scoreboard, which predicts
// the setting chosen by each accepted reading.
module tb_fan_level_hysteresis_selector;

	localparam int RANDOM_READINGS = 1200;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int TAIL_CYCLES     = 8;

	// how the receiver stalls during one stretch of cycles
	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// one expected output item
	typedef struct {
		logic [3:0] setting;
		logic [6:0] ctrl_byte;
		logic       by_rise;
	} fan_choice_t;

	// Tracks both band indices and holds the settings still to come out.
	class fan_choice_board_t;
		flhs_pkg::bands_t held;
		fan_choice_t      choice_q[$];
		int               errors;

		function new();
			held.fall_band = flhs_pkg::FALL_RESET;
			held.rise_band = flhs_pkg::RISE_RESET;
			errors = 0;
		endfunction

		function int pending();
			return choice_q.size();
		endfunction

		task report(string what, int got, int want);
			$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		// accepted input item: update the bands, queue a setting if one is chosen
		function void note_reading(logic [15:0] reading, logic ok);
			int          fi;
			int          ri;
			logic [15:0] even;
			logic        hit;
			fan_choice_t c;
			if (!ok)
				return;
			hit = 1'b0;
			c.by_rise = 1'b0;
			c.setting = '0;
			// falling band: first limit the reading does not strictly exceed
			fi = 0;
			while (fi < flhs_pkg::FALL_N - 1 && reading > flhs_pkg::FALL_LIMIT[fi])
				fi++;
			if (4'(fi) < held.fall_band) begin
				c.setting = flhs_pkg::FALL_LEVEL[fi];
				hit = 1'b1;
			end
			held.fall_band = 4'(fi);
			// rising band: compare with bit 0 dropped, from the second limit on
			even = reading & 16'hfffe;
			ri = 0;
			while (ri < flhs_pkg::RISE_N - 2 && even >= flhs_pkg::RISE_LIMIT[ri + 1])
				ri++;
			if (held.rise_band < 3'(ri)) begin
				c.setting = flhs_pkg::RISE_LEVEL[ri];
				c.by_rise = 1'b1;
				hit = 1'b1;
			end
			held.rise_band = 3'(ri);
			if (hit) begin
				c.ctrl_byte = {c.setting, 3'b111};
				choice_q.push_back(c);
			end
		endfunction

		// accepted output item: compare against the oldest queued setting
		task check_setting(logic [3:0] setting, logic [6:0] ctrl_byte, logic by_rise);
			fan_choice_t c;
			if (choice_q.size() == 0) begin
				report("output item with nothing pending", setting, 0);
				return;
			end
			c = choice_q.pop_front();
			if (setting !== c.setting)
				report("fan_level", setting, c.setting);
			if (ctrl_byte !== c.ctrl_byte)
				report("fan_control_byte", ctrl_byte, c.ctrl_byte);
			if (by_rise !== c.by_rise)
				report("chosen_by_rise", by_rise, c.by_rise);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] temp_reading;
	logic        reading_valid;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  fan_level;
	logic [6:0]  fan_control_byte;
	logic        chosen_by_rise;

	fan_choice_board_t board;

	// sender pacing and receiver stall pattern
	int          burst_left;
	stall_mode_t stall_mode;
	int          stall_left;
	int unsigned cyc;

	fan_level_hysteresis_selector u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.temp_reading     (temp_reading),
		.reading_valid    (reading_valid),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.fan_level        (fan_level),
		.fan_control_byte (fan_control_byte),
		.chosen_by_rise   (chosen_by_rise)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Both monitors run on the rising edge and see pre-edge values, so
	// acceptance here agrees with what the block itself registers.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_reading(temp_reading, reading_valid);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_setting(fan_level, fan_control_byte, chosen_by_rise);
	end

	// Receiver: switches between stall modes at random intervals, so
	// stalls land on every stage of the pipe, with clean stretches too.
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
			STALL_PERIODIC: out_stall <= ((cyc % 5) < 2);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Present one item and hold it until the block takes it.
	task automatic send_reading(logic [15:0] reading, logic ok);
		@(negedge clk);
		in_valid      <= 1'b1;
		temp_reading  <= reading;
		reading_valid <= ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Burst pacing: at the end of a burst, usually drop valid for a while.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
		burst_left--;
	endtask

	// Go quiet until every queued setting is out, or DRAIN_LIMIT is hit.
	task automatic drain();
		int n;
		@(negedge clk);
		in_valid <= 1'b0;
		n = 0;
		while (board.pending() > 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
	endtask

	// Random reading: mostly a walk through the band region so that both
	// tables keep crossing limits, then near-limit picks and raw noise.
	function automatic logic [15:0] pick_reading(logic [15:0] prev);
		int sel;
		int v;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			if (prev < 16'h3600 || prev > 16'h3e00)
				v = $urandom_range(16'h3600, 16'h3d00);
			else
				v = int'(prev) + int'($urandom_range(0, 256)) - 128;
		end else if (sel < 80) begin
			if ($urandom_range(0, 1) == 1)
				v = int'(flhs_pkg::FALL_LIMIT[$urandom_range(0, flhs_pkg::FALL_N - 1)]);
			else
				v = int'(flhs_pkg::RISE_LIMIT[$urandom_range(0, flhs_pkg::RISE_N - 1)]);
			v = v + int'($urandom_range(0, 4)) - 2;
		end else begin
			v = $urandom_range(0, 16'hffff);
		end
		if (v < 0)
			v = 0;
		if (v > 16'hffff)
			v = 16'hffff;
		return 16'(v);
	endfunction

	initial begin
		logic [15:0] reading;
		logic        ok;
		int          sent;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		temp_reading  = '0;
		reading_valid = 1'b0;
		out_stall     = 1'b0;
		burst_left    = 0;
		stall_mode    = STALL_NONE;
		stall_left    = 0;
		cyc           = 0;
		board = new();

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: invalid reads, repeats with no change, both sides of
		// several limits (odd rising limits with bit 0 dropped), table tops.
		send_reading(16'hffff, 1'b0);
		send_reading(16'h0000, 1'b1);
		send_reading(16'h0000, 1'b1);
		send_reading(16'h3700, 1'b1);
		send_reading(16'h3701, 1'b1);
		send_reading(16'h374a, 1'b1);
		send_reading(16'h374b, 1'b1);
		send_reading(16'h3900, 1'b1);
		send_reading(16'h0000, 1'b0);
		send_reading(16'h3ad3, 1'b1);
		send_reading(16'h3ad4, 1'b1);
		send_reading(16'h3be3, 1'b1);
		send_reading(16'h3be4, 1'b1);
		send_reading(16'h3c29, 1'b1);
		send_reading(16'h3c2a, 1'b1);
		send_reading(16'hfffe, 1'b1);
		send_reading(16'hffff, 1'b1);
		send_reading(16'h3c29, 1'b1);
		send_reading(16'h3800, 1'b1);
		send_reading(16'h3801, 1'b1);
		send_reading(16'h0001, 1'b1);
		send_reading(16'h5555, 1'b1);
		send_reading(16'haaaa, 1'b1);

		// Random part; skipped reads come on top of the count.
		reading = 16'h3800;
		sent = 0;
		while (sent < RANDOM_READINGS) begin
			if (sent == RANDOM_READINGS / 2)
				drain();
			pace_sender();
			ok = ($urandom_range(0, 99) >= 8);
			if (ok) begin
				reading = pick_reading(reading);
				send_reading(reading, 1'b1);
				sent++;
			end else begin
				send_reading(16'($urandom_range(0, 16'hffff)), 1'b0);
			end
		end

		drain();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (board.pending() > 0)
			board.report("settings never produced", 0, board.pending());

		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop, far above the slowest legal run.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
